// File: hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared types and codes of the complex arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    // operation codes
    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // classified item passed from front to back
    typedef struct packed {
        action_t             action;
        logic signed [16:0]  sum_r;
        logic signed [16:0]  sum_i;
        logic signed [31:0]  p_rr;
        logic signed [31:0]  p_ii;
        logic signed [31:0]  p_ir;
        logic signed [31:0]  p_ri;
        logic        [30:0]  sq_r;
        logic        [30:0]  sq_i;
    } entry_t;

endpackage

`default_nettype wire

// File: hdl/cau_if.sv
// ----------------------------------------------------------------------------
// cau channel interfaces
// valid/ready channels for operand items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic signed [15:0] a_real;
    logic signed [15:0] a_imag;
    logic signed [15:0] b_real;
    logic signed [15:0] b_imag;

    modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] res_real;
    logic signed [15:0] res_imag;
    logic        [1:0]  status;

    modport source (output valid, res_real, res_imag, status, input ready);
    modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

`default_nettype wire

// File: hdl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// accepts operand items, forms sums and all partial products
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    cau_in_if.sink              in_ch,
    output logic                push_valid,
    input  wire logic           push_ready,
    output cau_pkg::entry_t     push_entry
);

    logic               s1_valid_reg;
    cau_pkg::action_t   s1_action_reg;
    logic signed [15:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic               s2_valid_reg;
    cau_pkg::entry_t    s2_entry_reg;
    cau_pkg::entry_t    s2_next;
    logic               adv;

    // whole front moves when its last stage is empty or drained
    assign adv         = !s2_valid_reg || push_ready;
    assign in_ch.ready = adv;
    assign push_valid  = s2_valid_reg;
    assign push_entry  = s2_entry_reg;

    // sums and products of the operand stage
    always_comb
    begin
        s2_next.action = s1_action_reg;
        s2_next.sum_r  = 17'(s1_ar_reg) + 17'(s1_br_reg);
        s2_next.sum_i  = 17'(s1_ai_reg) + 17'(s1_bi_reg);
        if (s1_action_reg == cau_pkg::ACT_SUB)
        begin
            s2_next.sum_r = 17'(s1_ar_reg) - 17'(s1_br_reg);
            s2_next.sum_i = 17'(s1_ai_reg) - 17'(s1_bi_reg);
        end
        s2_next.p_rr = s1_ar_reg * s1_br_reg;
        s2_next.p_ii = s1_ai_reg * s1_bi_reg;
        s2_next.p_ir = s1_ai_reg * s1_br_reg;
        s2_next.p_ri = s1_ar_reg * s1_bi_reg;
        s2_next.sq_r = 31'(32'(s1_br_reg * s1_br_reg));
        s2_next.sq_i = 31'(32'(s1_bi_reg * s1_bi_reg));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_ch.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_action_reg <= cau_pkg::action_t'(in_ch.action);
            s1_ar_reg     <= in_ch.a_real;
            s1_ai_reg     <= in_ch.a_imag;
            s1_br_reg     <= in_ch.b_real;
            s1_bi_reg     <= in_ch.b_imag;
            s2_entry_reg  <= s2_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/cau_fifo.sv
// ----------------------------------------------------------------------------
// cau_fifo
// short queue decoupling the front from the back
// ----------------------------------------------------------------------------
`default_nettype none

module cau_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire cau_pkg::entry_t push_entry,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output cau_pkg::entry_t     pop_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cau_pkg::entry_t mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// File: hdl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// combines products, runs the pipelined divider, saturates and presents results
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire cau_pkg::entry_t pop_entry,
    cau_out_if.source            out_ch
);

    localparam int W     = 49 + FRAC_BITS;
    localparam int QB    = 17;
    localparam int NST   = QB;

    typedef struct packed {
        logic [W-1:0]       rem_r;
        logic [W-1:0]       rem_i;
        logic [31:0]        d;
        logic [QB-1:0]      q_r;
        logic [QB-1:0]      q_i;
        logic               neg_r;
        logic               neg_i;
        logic               ovf_r;
        logic               ovf_i;
        logic               is_div;
        logic               divz;
        logic signed [15:0] pr;
        logic signed [15:0] pi;
        logic [1:0]         pst;
    } stage_t;

    function automatic logic signed [15:0] clamp16(input logic signed [34:0] v);
        if (v > 35'sd32767)
            return 16'sh7fff;
        else if (v < -35'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic is_sat(input logic signed [34:0] v);
        return (v > 35'sd32767) || (v < -35'sd32768);
    endfunction

    logic               adv;
    logic               st_valid_reg [NST+1];
    stage_t             st_reg       [NST+1];
    stage_t             a_next;
    logic               out_valid_reg;
    logic signed [15:0] out_r_reg, out_i_reg;
    logic [1:0]         out_st_reg;

    // back pipeline moves when the output register is free or taken
    assign adv       = !out_valid_reg || out_ch.ready;
    assign pop_ready = adv;

    // combine stage: finish add/sub/mul, set up division
    always_comb
    begin
        logic signed [33:0] mr, mi, nr, ni, mr_t, mi_t, rnd;
        logic        [32:0] mag_r, mag_i;
        mr = 34'(pop_entry.p_rr) - 34'(pop_entry.p_ii);
        mi = 34'(pop_entry.p_ir) + 34'(pop_entry.p_ri);
        nr = 34'(pop_entry.p_rr) + 34'(pop_entry.p_ii);
        ni = 34'(pop_entry.p_ir) - 34'(pop_entry.p_ri);
        // truncate toward zero on the scale-down
        rnd  = 34'((35'd1 << FRAC_BITS) - 35'd1);
        mr_t = (mr + (mr[33] ? rnd : 34'sd0)) >>> FRAC_BITS;
        mi_t = (mi + (mi[33] ? rnd : 34'sd0)) >>> FRAC_BITS;
        mag_r = nr[33] ? 33'(-nr) : 33'(nr);
        mag_i = ni[33] ? 33'(-ni) : 33'(ni);

        a_next        = '0;
        a_next.rem_r  = W'(mag_r) << FRAC_BITS;
        a_next.rem_i  = W'(mag_i) << FRAC_BITS;
        a_next.d      = 32'(pop_entry.sq_r) + 32'(pop_entry.sq_i);
        a_next.neg_r  = nr[33];
        a_next.neg_i  = ni[33];
        a_next.is_div = (pop_entry.action == cau_pkg::ACT_DIV);
        a_next.divz   = (pop_entry.sq_r == '0) && (pop_entry.sq_i == '0);
        unique case (pop_entry.action)
            cau_pkg::ACT_ADD, cau_pkg::ACT_SUB:
            begin
                a_next.pr  = clamp16(35'(pop_entry.sum_r));
                a_next.pi  = clamp16(35'(pop_entry.sum_i));
                a_next.pst = (is_sat(35'(pop_entry.sum_r)) || is_sat(35'(pop_entry.sum_i)))
                             ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            cau_pkg::ACT_MUL:
            begin
                a_next.pr  = clamp16(35'(mr_t));
                a_next.pi  = clamp16(35'(mi_t));
                a_next.pst = (is_sat(35'(mr_t)) || is_sat(35'(mi_t)))
                             ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default:
            begin
                a_next.pr  = '0;
                a_next.pi  = '0;
                a_next.pst = cau_pkg::ST_OK;
            end
        endcase
    end

    // combine stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg[0] <= 1'b0;
        else if (adv)
            st_valid_reg[0] <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            st_reg[0] <= a_next;
    end

    // restoring divider, one quotient bit per stage for both parts
    for (genvar s = 0; s < NST; s++)
    begin : g_div
        localparam int B = QB - 1 - s;
        stage_t nxt;
        always_comb
        begin
            logic [W-1:0] dsh;
            nxt = st_reg[s];
            dsh = W'(st_reg[s].d) << B;
            if (s == 0)
            begin
                nxt.ovf_r = st_reg[s].rem_r >= (W'(st_reg[s].d) << QB);
                nxt.ovf_i = st_reg[s].rem_i >= (W'(st_reg[s].d) << QB);
            end
            if (st_reg[s].rem_r >= dsh)
            begin
                nxt.rem_r  = st_reg[s].rem_r - dsh;
                nxt.q_r[B] = 1'b1;
            end
            if (st_reg[s].rem_i >= dsh)
            begin
                nxt.rem_i  = st_reg[s].rem_i - dsh;
                nxt.q_i[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_valid_reg[s+1] <= 1'b0;
            else if (adv)
                st_valid_reg[s+1] <= st_valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                st_reg[s+1] <= nxt;
        end
    end

    // sign, saturation and status of quotients
    stage_t             fin;
    logic signed [34:0] vr, vi;
    logic               sr, si;
    logic signed [15:0] fr_next, fi_next;
    logic [1:0]         fst_next;

    assign fin = st_reg[NST];

    always_comb
    begin
        vr = fin.neg_r ? -35'(fin.q_r) : 35'(fin.q_r);
        vi = fin.neg_i ? -35'(fin.q_i) : 35'(fin.q_i);
        sr = fin.ovf_r || is_sat(vr);
        si = fin.ovf_i || is_sat(vi);
        if (!fin.is_div)
        begin
            fr_next  = fin.pr;
            fi_next  = fin.pi;
            fst_next = fin.pst;
        end
        else if (fin.divz)
        begin
            fr_next  = '0;
            fi_next  = '0;
            fst_next = cau_pkg::ST_DIVZ;
        end
        else
        begin
            fr_next  = sr ? (fin.neg_r ? 16'sh8000 : 16'sh7fff) : vr[15:0];
            fi_next  = si ? (fin.neg_i ? 16'sh8000 : 16'sh7fff) : vi[15:0];
            fst_next = (sr || si) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= st_valid_reg[NST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_r_reg  <= fr_next;
            out_i_reg  <= fi_next;
            out_st_reg <= fst_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.res_real = out_r_reg;
    assign out_ch.res_imag = out_i_reg;
    assign out_ch.status   = out_st_reg;

endmodule

`default_nettype wire

// File: hdl/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// complex add, subtract, multiply and divide on signed fixed-point operands
// ----------------------------------------------------------------------------
// in_ch carries one operation and two complex operands a and b per transfer;
// out_ch returns one transfer per item with the saturated real and imaginary
// parts and a status (ok, saturated, divide by zero).
// The front registers the operands and forms all 16x16 products, then pushes
// the item into a four-entry queue. The back combines the products and runs
// a 17-stage restoring divider, one quotient bit per stage, for both parts;
// every operation goes through the same pipeline so results stay in order.
// An item passes two front registers, the queue, the combine and divider
// stages and the output register. Throughput is one item per cycle unless
// out_ch stalls, as every stage, divider included, takes an item each cycle.
// When out_ch is stalled the back holds, the queue fills, and in_ch.ready
// drops once the queue is full and the last front stage holds an item.
// Reset clears all valid flags; the block is empty afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cau_in_if.sink    in_ch,
    cau_out_if.source out_ch
);

    logic            push_valid, push_ready, pop_valid, pop_ready;
    cau_pkg::entry_t push_entry, pop_entry;

    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    cau_fifo #(
        .DEPTH (4)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
